// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted-store priority queue
// Store geometry, word field types, status codes and sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int DATA_BITS  = 32;
  localparam int STAT_BITS  = 2;
  localparam int OCC_BITS   = 5;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [STAT_BITS-1:0]  stat_t;
  typedef logic [OCC_BITS-1:0]   occ_t;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_PUT,
    S_DEQ_RD,
    S_DEQ_HEAD,
    S_DEQ_SRD,
    S_DEQ_SWR,
    S_FIN
  } state_t;

  typedef struct packed {
    status_t status;
    val_t    removed;
    cnt_t    occupancy;
  } result_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    val_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } ram_rd_t;

endpackage

// ===== sv/spq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_if: request and response channels
// Valid/ready channels carrying queue requests and queue results.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  spq_pkg::data_t       value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface spq_rsp_if;
  logic                 valid;
  logic                 ready;
  spq_pkg::stat_t       status;
  spq_pkg::data_t       removed_value;
  spq_pkg::occ_t        occupancy;

  modport source (output valid, output status, output removed_value,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input occupancy, output ready);
endinterface

// ===== sv/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/spq_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_seq: queue sequencer
// Walks the sorted store one entry at a time through a single compare unit:
// insertion shifts larger entries up, removal shifts the tail down.
// ----------------------------------------------------------------------------
module spq_seq (
  input  logic               clk,
  input  logic               rst,
  spq_req_if.sink            req,
  output spq_pkg::ram_wr_t   wr,
  output spq_pkg::ram_rd_t   rd,
  input  spq_pkg::val_t      rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output spq_pkg::result_t   res
);

  spq_pkg::state_t  state;
  spq_pkg::state_t  state_next;
  spq_pkg::idx_t    idx;
  spq_pkg::cnt_t    cnt;
  spq_pkg::cnt_t    cnt_upd;
  spq_pkg::val_t    val;
  spq_pkg::val_t    removed;
  spq_pkg::status_t status;
  logic             deq;
  logic             less;

  assign less = $signed(val) < $signed(rd_data);

  always_comb begin
    if (status != spq_pkg::ST_DONE) begin
      cnt_upd = cnt;
    end else if (deq) begin
      cnt_upd = cnt - spq_pkg::cnt_t'(1);
    end else begin
      cnt_upd = cnt + spq_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.action == spq_pkg::ACT_ENQ) begin
            if (cnt == spq_pkg::cnt_t'(spq_pkg::DEPTH)) begin
              state_next = spq_pkg::S_FIN;
            end else if (cnt == '0) begin
              state_next = spq_pkg::S_ENQ_PUT;
            end else begin
              state_next = spq_pkg::S_ENQ_RD;
            end
          end else if (cnt == '0) begin
            state_next = spq_pkg::S_FIN;
          end else begin
            state_next = spq_pkg::S_DEQ_RD;
          end
        end
      end
      spq_pkg::S_ENQ_RD: state_next = spq_pkg::S_ENQ_CMP;
      spq_pkg::S_ENQ_CMP: begin
        if (!less) begin
          state_next = spq_pkg::S_FIN;
        end else if (idx == spq_pkg::idx_t'(1)) begin
          state_next = spq_pkg::S_ENQ_PUT;
        end else begin
          state_next = spq_pkg::S_ENQ_RD;
        end
      end
      spq_pkg::S_ENQ_PUT: state_next = spq_pkg::S_FIN;
      spq_pkg::S_DEQ_RD:  state_next = spq_pkg::S_DEQ_HEAD;
      spq_pkg::S_DEQ_HEAD: begin
        if (cnt == spq_pkg::cnt_t'(1)) begin
          state_next = spq_pkg::S_FIN;
        end else begin
          state_next = spq_pkg::S_DEQ_SRD;
        end
      end
      spq_pkg::S_DEQ_SRD: state_next = spq_pkg::S_DEQ_SWR;
      spq_pkg::S_DEQ_SWR: begin
        if (spq_pkg::cnt_t'(idx) + spq_pkg::cnt_t'(1) == cnt) begin
          state_next = spq_pkg::S_FIN;
        end else begin
          state_next = spq_pkg::S_DEQ_SRD;
        end
      end
      spq_pkg::S_FIN: begin
        if (res_ready) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    wr        = '0;
    rd        = '0;
    res_valid = 1'b0;
    unique case (state)
      spq_pkg::S_IDLE: req.ready = 1'b1;
      spq_pkg::S_ENQ_RD: begin
        rd.en   = 1'b1;
        rd.addr = idx - spq_pkg::idx_t'(1);
      end
      spq_pkg::S_ENQ_CMP: begin
        wr.en   = 1'b1;
        wr.addr = idx;
        wr.data = less ? rd_data : val;
      end
      spq_pkg::S_ENQ_PUT: begin
        wr.en   = 1'b1;
        wr.addr = idx;
        wr.data = val;
      end
      spq_pkg::S_DEQ_RD: begin
        rd.en   = 1'b1;
        rd.addr = '0;
      end
      spq_pkg::S_DEQ_HEAD: ;
      spq_pkg::S_DEQ_SRD: begin
        rd.en   = 1'b1;
        rd.addr = idx;
      end
      spq_pkg::S_DEQ_SWR: begin
        wr.en   = 1'b1;
        wr.addr = idx - spq_pkg::idx_t'(1);
        wr.data = rd_data;
      end
      spq_pkg::S_FIN: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.status    = status;
  assign res.removed   = removed;
  assign res.occupancy = cnt_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == spq_pkg::S_FIN && res_ready) begin
        cnt <= cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      spq_pkg::S_IDLE: begin
        if (req.valid) begin
          val     <= spq_pkg::val_t'(req.value);
          idx     <= spq_pkg::idx_t'(cnt);
          removed <= '0;
          deq     <= (req.action == spq_pkg::ACT_DEQ);
          if (req.action == spq_pkg::ACT_ENQ) begin
            status <= (cnt == spq_pkg::cnt_t'(spq_pkg::DEPTH)) ?
                      spq_pkg::ST_OVERFLOW : spq_pkg::ST_DONE;
          end else begin
            status <= (cnt == '0) ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_DONE;
          end
        end
      end
      spq_pkg::S_ENQ_CMP: begin
        if (less) begin
          idx <= idx - spq_pkg::idx_t'(1);
        end
      end
      spq_pkg::S_DEQ_HEAD: begin
        removed <= rd_data;
        idx     <= spq_pkg::idx_t'(1);
      end
      spq_pkg::S_DEQ_SWR: idx <= idx + spq_pkg::idx_t'(1);
      default: ;
    endcase
  end

endmodule

// ===== sv/sorted_insert_min_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_min_priority_queue: bounded min-priority queue
// Enqueue: compares held values with the new one from the tail down, moving
//   each larger one up a slot, then writes the new value into the gap;
//   dequeue reads the head, then moves every later entry down a slot; a
//   refused word goes straight to the result.
// Flow: one word at a time, the next taken once the last result has passed
//   on; entries move through the store's single, registered read port.
// Reset: rst empties the queue; store contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_min_priority_queue (
  input  logic     clk,
  input  logic     rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  spq_pkg::ram_wr_t wr;
  spq_pkg::ram_rd_t rd;
  spq_pkg::val_t    rd_data;
  spq_pkg::result_t res;
  spq_pkg::result_t out_res;
  logic             res_valid;
  logic             res_ready;
  logic             out_valid;

  spq_ram #(
    .WIDTH (spq_pkg::VALUE_BITS),
    .DEPTH (spq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (rd_data)
  );

  spq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr        (wr),
    .rd        (rd),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = spq_pkg::stat_t'(out_res.status);
  assign rsp.removed_value = spq_pkg::data_t'(out_res.removed);
  assign rsp.occupancy     = spq_pkg::occ_t'(out_res.occupancy);

endmodule

// ===== sv/spq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_chk: port checker for the priority queue
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module spq_chk (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  spq_pkg::stat_t rsp_status,
  input  spq_pkg::data_t rsp_removed_value,
  input  spq_pkg::occ_t  rsp_occupancy
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in flight");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == spq_pkg::ST_OVERFLOW |->
      rsp_occupancy == spq_pkg::occ_t'(spq_pkg::DEPTH) && rsp_removed_value == '0)
    else $error("overflow reported below full occupancy");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == spq_pkg::ST_UNDERFLOW |->
      rsp_occupancy == '0 && rsp_removed_value == '0)
    else $error("underflow reported on a non-empty queue");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_occupancy <= spq_pkg::occ_t'(spq_pkg::DEPTH))
    else $error("occupancy beyond capacity");

endmodule

bind sorted_insert_min_priority_queue spq_chk u_spq_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_removed_value (rsp.removed_value),
  .rsp_occupancy     (rsp.occupancy)
);

// ===== test/sorted_insert_min_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_min_priority_queue_test: self-checking bench for the queue
// Sends enqueue and dequeue words over the request channel. A sorted copy of
// the held values predicts the status, removed value and occupancy of every
// accepted word, and each response is checked against that prediction.
// Runs through four throttling phases on the request and response sides.
// ----------------------------------------------------------------------------
module sorted_insert_min_priority_queue_test;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 238;

  typedef struct {
    logic           action;
    spq_pkg::data_t value;
  } queue_word_t;

  typedef struct {
    spq_pkg::stat_t status;
    spq_pkg::data_t removed;
    spq_pkg::occ_t  occupancy;
  } queue_result_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_insert_min_priority_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_word_t    upcoming_words[$];
  queue_result_t  predicted_results[$];
  spq_pkg::val_t  held_values[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  int             mismatch_count;
  int             cycle_count;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic queue_result_t predict_queue_op(logic action,
                                                     spq_pkg::data_t value);
    queue_result_t r;
    int            pos;
    r.status  = spq_pkg::ST_DONE;
    r.removed = '0;
    if (action == spq_pkg::ACT_ENQ) begin
      if (held_values.size() >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        pos = held_values.size();
        while (pos > 0 && $signed(value) < $signed(held_values[pos-1])) pos--;
        held_values.insert(pos, value);
      end
    end else begin
      if (held_values.size() == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.removed = held_values.pop_front();
      end
    end
    r.occupancy = spq_pkg::occ_t'(held_values.size());
    return r;
  endfunction

  function automatic spq_pkg::data_t pick_value();
    spq_pkg::data_t v;
    case ($urandom_range(3))
      0: v = spq_pkg::data_t'($urandom_range(6)) - spq_pkg::data_t'(3);
      1: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          4: v = 32'h8000_0001;
          default: v = 32'h7fff_fffe;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_word(logic action, spq_pkg::data_t value);
    queue_word_t w;
    w.action = action;
    w.value  = value;
    upcoming_words.push_back(w);
  endtask

  // Runs of enqueues and dequeues push the queue to full and to empty often.
  task automatic add_random_words(int count);
    int   added;
    int   run_len;
    logic run_action;
    added = 0;
    while (added < count) begin
      run_action = 1'($urandom_range(1));
      run_len    = $urandom_range(1, 20);
      for (int i = 0; i < run_len && added < count; i++) begin
        if ($urandom_range(7) == 0) begin
          add_word(~run_action, pick_value());
        end else begin
          add_word(run_action, pick_value());
        end
        added++;
      end
    end
  endtask

  // Driver: hold a word until it is taken, then advance.
  always @(posedge clk) begin
    queue_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_results.push_back(predict_queue_op(req_ch.action, req_ch.value));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (upcoming_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = upcoming_words.pop_front();
          req_ch.valid  <= 1'b1;
          req_ch.action <= w.action;
          req_ch.value  <= w.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response word against the oldest prediction.
  always @(posedge clk) begin
    queue_result_t r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: response word with none expected: status %0d removed %0h occ %0d",
                 $time, rsp_ch.status, rsp_ch.removed_value, rsp_ch.occupancy);
        mismatch_count++;
      end else begin
        r = predicted_results.pop_front();
        if (rsp_ch.status !== r.status) begin
          $display("%0t: status expected %0d, got %0d", $time, r.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.removed_value !== r.removed) begin
          $display("%0t: removed_value expected %0h, got %0h",
                   $time, r.removed, rsp_ch.removed_value);
          mismatch_count++;
        end
        if (rsp_ch.occupancy !== r.occupancy) begin
          $display("%0t: occupancy expected %0d, got %0d",
                   $time, r.occupancy, rsp_ch.occupancy);
          mismatch_count++;
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_insert_min_priority_queue_test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (upcoming_words.size() > 0 || req_ch.valid || predicted_results.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    req_ch.valid   = 1'b0;
    req_ch.action  = spq_pkg::ACT_ENQ;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_word(spq_pkg::ACT_DEQ, 32'hffff_ffff);
    add_word(spq_pkg::ACT_ENQ, 32'h7fff_ffff);
    add_word(spq_pkg::ACT_ENQ, 32'h8000_0000);
    add_word(spq_pkg::ACT_ENQ, 32'h0000_0000);
    add_word(spq_pkg::ACT_ENQ, 32'hffff_ffff);
    add_word(spq_pkg::ACT_ENQ, 32'h0000_0007);
    add_word(spq_pkg::ACT_ENQ, 32'h0000_0007);
    add_word(spq_pkg::ACT_ENQ, 32'h8000_0000);
    add_word(spq_pkg::ACT_ENQ, 32'h7fff_ffff);
    for (int i = 0; i < 8; i++) add_word(spq_pkg::ACT_ENQ, $urandom);
    add_word(spq_pkg::ACT_ENQ, 32'h0000_0001);
    add_word(spq_pkg::ACT_DEQ, 32'h0000_0000);
    add_word(spq_pkg::ACT_DEQ, $urandom);
    add_word(spq_pkg::ACT_ENQ, 32'h8000_0000);
    add_word(spq_pkg::ACT_DEQ, 32'h7fff_ffff);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      add_random_words(PHASE_WORDS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_insert_min_priority_queue_test passed");
    end else begin
      $display("sorted_insert_min_priority_queue_test failed");
    end
    $finish;
  end

endmodule
